[hw/rtl/fehu_pkg.sv]
// ----------------------------------------------------------------------------
// fehu_pkg: shared types for the fire heat update block
// Command codes of the input beat and the item classes that the front end
// hands to the back end.
// ----------------------------------------------------------------------------
package fehu_pkg;

  localparam int HEAT_W = 8;

  typedef enum logic {
    CMD_SEED   = 1'b0,
    CMD_UPDATE = 1'b1
  } cmd_e;

  // Class of an item once its coordinates have been checked.
  typedef enum logic [1:0] {
    KIND_BAD    = 2'd0,
    KIND_SEED   = 2'd1,
    KIND_READ   = 2'd2,
    KIND_UPDATE = 2'd3
  } kind_e;

endpackage

[hw/rtl/fehu_ram.sv]
// ----------------------------------------------------------------------------
// fehu_ram: generic RAM with one write port and one registered read port
// Read data changes only when a read is enabled and holds otherwise.
// ----------------------------------------------------------------------------
module fehu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[hw/rtl/fehu_queue.sv]
// ----------------------------------------------------------------------------
// fehu_queue: short FIFO between the front and back ends
// The head entry stays put until it is popped.
// ----------------------------------------------------------------------------
module fehu_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2,
  localparam int PW = $clog2(DEPTH),
  localparam int CNTW = $clog2(DEPTH + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             empty_o,
  output logic [WIDTH-1:0] data_o
);

  logic [WIDTH-1:0] slot_q [DEPTH];
  logic [PW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [PW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [CNTW-1:0]  count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CNTW'(DEPTH));
  assign empty_o = (count_q == '0);
  assign data_o  = slot_q[rd_ptr_q];

  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CNTW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CNTW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

[hw/rtl/fehu_front.sv]
// ----------------------------------------------------------------------------
// fehu_front: input handshake and item classification
// Checks coordinates, works out the wrapped neighbor coordinates and pushes
// one classified entry per accepted beat into the queue.
// ----------------------------------------------------------------------------
module fehu_front import fehu_pkg::*; #(
  parameter int GRID_WIDTH  = 800,
  parameter int GRID_HEIGHT = 600,
  localparam int CW = $clog2(GRID_WIDTH),
  localparam int RW = $clog2(GRID_HEIGHT),
  localparam int EW = $bits(kind_e) + 3 * CW + 3 * RW + HEAT_W
) (
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              cmd_i,
  input  logic [9:0]        col_i,
  input  logic [9:0]        row_i,
  input  logic [HEAT_W-1:0] seed_heat_i,
  input  logic              q_full_i,
  input  logic              clearing_i,
  output logic              q_push_o,
  output logic [EW-1:0]     q_entry_o
);

  typedef struct packed {
    kind_e             kind;
    logic [CW-1:0]     col;
    logic [CW-1:0]     col_l;
    logic [CW-1:0]     col_r;
    logic [RW-1:0]     row;
    logic [RW-1:0]     row_1;
    logic [RW-1:0]     row_2;
    logic [HEAT_W-1:0] seed_heat;
  } entry_t;

  entry_t        entry;
  logic          col_ok, row_ok;
  logic [CW-1:0] col;
  logic [RW-1:0] row;

  assign col_ok = (32'(col_i) < GRID_WIDTH);
  assign row_ok = (32'(row_i) < GRID_HEIGHT);
  assign col    = CW'(32'(col_i));
  assign row    = RW'(32'(row_i));

  always_comb begin
    entry.col       = col;
    entry.col_r     = (col == CW'(GRID_WIDTH - 1)) ? '0 : col + CW'(1);
    entry.col_l     = (col == '0) ? CW'(GRID_WIDTH - 1) : col - CW'(1);
    entry.row       = row;
    entry.row_1     = (row == RW'(GRID_HEIGHT - 1)) ? '0 : row + RW'(1);
    entry.row_2     = (row == RW'(GRID_HEIGHT - 2)) ? '0 :
                      (row == RW'(GRID_HEIGHT - 1)) ? RW'(1) : row + RW'(2);
    entry.seed_heat = seed_heat_i;

    if (!col_ok || (cmd_i == CMD_UPDATE && !row_ok)) begin
      entry.kind = KIND_BAD;
    end else if (cmd_i == CMD_SEED) begin
      // A seed always lands on the bottom row, whatever the row field says.
      entry.kind = KIND_SEED;
      entry.row  = RW'(GRID_HEIGHT - 1);
    end else if (row == RW'(GRID_HEIGHT - 1)) begin
      entry.kind = KIND_READ;
    end else begin
      entry.kind = KIND_UPDATE;
    end
  end

  assign in_ready_o = !q_full_i && !clearing_i;
  assign q_push_o   = in_valid_i && in_ready_o;
  assign q_entry_o  = entry;

endmodule

[hw/rtl/fehu_back.sv]
// ----------------------------------------------------------------------------
// fehu_back: grid sequencer, heat arithmetic and result register
// Clears the grid after reset, then executes queued entries against the
// heat RAM and delivers one result beat per entry.
// ----------------------------------------------------------------------------
module fehu_back import fehu_pkg::*; #(
  parameter int GRID_WIDTH  = 800,
  parameter int GRID_HEIGHT = 600,
  localparam int CW = $clog2(GRID_WIDTH),
  localparam int RW = $clog2(GRID_HEIGHT),
  localparam int EW = $bits(kind_e) + 3 * CW + 3 * RW + HEAT_W
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              q_empty_i,
  input  logic [EW-1:0]     q_head_i,
  output logic              q_pop_o,
  output logic              clearing_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [HEAT_W-1:0] heat_o,
  output logic [7:0]        red_o,
  output logic [7:0]        green_o,
  output logic [6:0]        blue_o,
  output logic              bad_coord_o
);

  localparam int DEPTH = GRID_WIDTH * GRID_HEIGHT;
  localparam int AW    = $clog2(DEPTH);
  localparam int SUM_W = HEAT_W + 2;

  // sum * 32 / 129 == (sum * 32514) >> 17, exact for every four-cell sum.
  localparam int DIV_MUL    = 32514;
  localparam int DIV_SHIFT  = 17;
  localparam int DIV_PROD_W = SUM_W + 15;

  // h / 3 == (h * 171) >> 9 for any 8-bit h.
  localparam int THIRD_MUL   = 171;
  localparam int THIRD_SHIFT = 9;
  localparam int THIRD_W     = 16;
  localparam int RED_MUL     = 10;
  localparam int RED_SAT     = 26;

  typedef struct packed {
    kind_e             kind;
    logic [CW-1:0]     col;
    logic [CW-1:0]     col_l;
    logic [CW-1:0]     col_r;
    logic [RW-1:0]     row;
    logic [RW-1:0]     row_1;
    logic [RW-1:0]     row_2;
    logic [HEAT_W-1:0] seed_heat;
  } entry_t;

  typedef enum logic [6:0] {
    S_CLEAR = 7'b0000001,
    S_RUN   = 7'b0000010,
    S_LOOK  = 7'b0000100,
    S_RD1   = 7'b0001000,
    S_RD2   = 7'b0010000,
    S_RD3   = 7'b0100000,
    S_SUM   = 7'b1000000
  } state_e;

  state_e              state_q, state_d;
  logic [AW-1:0]       clr_q, clr_d;
  logic [SUM_W-1:0]    acc_q, acc_d;
  logic                res_valid_q, res_valid_d;
  logic [HEAT_W-1:0]   res_heat_q, res_heat_d;
  logic                res_bad_q, res_bad_d;

  entry_t              head;
  logic                out_free;
  logic                rd_en, wr_en, clr_wr;
  logic [RW-1:0]       rd_row;
  logic [CW-1:0]       rd_col;
  logic [HEAT_W-1:0]   wr_data;
  logic [AW-1:0]       rd_addr, wr_addr;
  logic                ram_we;
  logic [AW-1:0]       ram_waddr;
  logic [HEAT_W-1:0]   ram_wdata, rdata;
  logic [SUM_W-1:0]    sum;
  logic [DIV_PROD_W-1:0] div_prod;
  logic [HEAT_W-1:0]   new_heat;
  logic [7:0]          red_full;
  logic [THIRD_W-1:0]  third_prod;

  assign head     = q_head_i;
  assign out_free = !res_valid_q || out_ready_i;

  assign sum      = acc_q + SUM_W'(rdata);
  assign div_prod = DIV_PROD_W'(sum) * DIV_PROD_W'(DIV_MUL);
  assign new_heat = HEAT_W'(div_prod >> DIV_SHIFT);

  assign rd_addr  = AW'(rd_row) * AW'(GRID_WIDTH) + AW'(rd_col);
  assign wr_addr  = AW'(head.row) * AW'(GRID_WIDTH) + AW'(head.col);

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    acc_d       = acc_q;
    res_valid_d = res_valid_q && !out_ready_i;
    res_heat_d  = res_heat_q;
    res_bad_d   = res_bad_q;
    rd_en       = 1'b0;
    rd_row      = head.row;
    rd_col      = head.col;
    wr_en       = 1'b0;
    wr_data     = head.seed_heat;
    clr_wr      = 1'b0;
    q_pop_o     = 1'b0;

    case (state_q)
      S_CLEAR: begin
        clr_wr = 1'b1;
        clr_d  = clr_q + AW'(1);
        if (clr_q == AW'(DEPTH - 1)) begin
          state_d = S_RUN;
        end
      end
      S_RUN: begin
        if (!q_empty_i) begin
          case (head.kind)
            KIND_BAD: begin
              if (out_free) begin
                q_pop_o     = 1'b1;
                res_valid_d = 1'b1;
                res_heat_d  = '0;
                res_bad_d   = 1'b1;
              end
            end
            KIND_SEED: begin
              if (out_free) begin
                wr_en       = 1'b1;
                q_pop_o     = 1'b1;
                res_valid_d = 1'b1;
                res_heat_d  = head.seed_heat;
                res_bad_d   = 1'b0;
              end
            end
            KIND_READ: begin
              rd_en   = 1'b1;
              state_d = S_LOOK;
            end
            KIND_UPDATE: begin
              rd_en   = 1'b1;
              rd_row  = head.row_1;
              rd_col  = head.col_r;
              state_d = S_RD1;
            end
            default: ;
          endcase
        end
      end
      S_LOOK: begin
        if (out_free) begin
          q_pop_o     = 1'b1;
          res_valid_d = 1'b1;
          res_heat_d  = rdata;
          res_bad_d   = 1'b0;
          state_d     = S_RUN;
        end
      end
      S_RD1: begin
        acc_d   = SUM_W'(rdata);
        rd_en   = 1'b1;
        rd_row  = head.row_1;
        rd_col  = head.col;
        state_d = S_RD2;
      end
      S_RD2: begin
        acc_d   = sum;
        rd_en   = 1'b1;
        rd_row  = head.row_1;
        rd_col  = head.col_l;
        state_d = S_RD3;
      end
      S_RD3: begin
        acc_d   = sum;
        rd_en   = 1'b1;
        rd_row  = head.row_2;
        rd_col  = head.col;
        state_d = S_SUM;
      end
      S_SUM: begin
        // The last neighbor is still on the read port and holds while stalled.
        if (out_free) begin
          wr_en       = 1'b1;
          wr_data     = new_heat;
          q_pop_o     = 1'b1;
          res_valid_d = 1'b1;
          res_heat_d  = new_heat;
          res_bad_d   = 1'b0;
          state_d     = S_RUN;
        end
      end
      default: begin
        state_d = S_RUN;
      end
    endcase
  end

  assign ram_we    = wr_en || clr_wr;
  assign ram_waddr = clr_wr ? clr_q : wr_addr;
  assign ram_wdata = clr_wr ? '0 : wr_data;

  fehu_ram #(
    .WIDTH (HEAT_W),
    .DEPTH (DEPTH)
  ) u_grid (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q      <= acc_d;
    res_heat_q <= res_heat_d;
    res_bad_q  <= res_bad_d;
  end

  // Palette from the registered heat. Below the saturation point the red
  // product fits in eight bits.
  assign red_full   = 8'(res_heat_q) * 8'(RED_MUL);
  assign third_prod = THIRD_W'(res_heat_q) * THIRD_W'(THIRD_MUL);

  assign clearing_o  = (state_q == S_CLEAR);
  assign out_valid_o = res_valid_q;
  assign heat_o      = res_heat_q;
  assign red_o       = (res_heat_q >= HEAT_W'(RED_SAT)) ? 8'hFF : red_full;
  assign green_o     = res_heat_q[7] ? 8'hFF : {res_heat_q[6:0], 1'b0};
  assign blue_o      = 7'(third_prod >> THIRD_SHIFT);
  assign bad_coord_o = res_bad_q;

endmodule

[hw/rtl/fire_effect_heat_update_top.sv]
// ----------------------------------------------------------------------------
// fire_effect_heat_update_top: fire effect heat grid with palette output
//
//   channel | direction | handshake               | payload
//   --------+-----------+-------------------------+--------------------------------
//   in      | input     | in_valid_i / in_ready_o | cmd_i col_i row_i seed_heat_i
//   out     | output    | out_valid_o/out_ready_i | heat_o red_o green_o blue_o
//           |           |                         | bad_coord_o
//
// In the back end an update beat makes four neighbor reads on the single read
// port of the grid RAM, then the write of the new heat.
// A seed or out-of-range beat ends in S_RUN, a bottom-row update in S_LOOK.
// After reset the grid is cleared one cell per cycle, all GRID_WIDTH*GRID_HEIGHT
// cells (480000 by default), and in_ready_o stays low until it is done.
// A two-entry queue takes input beats while the result waits on out_ready_i.
// ----------------------------------------------------------------------------
module fire_effect_heat_update_top import fehu_pkg::*; #(
  parameter int GRID_WIDTH  = 800,
  parameter int GRID_HEIGHT = 600
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              cmd_i,
  input  logic [9:0]        col_i,
  input  logic [9:0]        row_i,
  input  logic [HEAT_W-1:0] seed_heat_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [HEAT_W-1:0] heat_o,
  output logic [7:0]        red_o,
  output logic [7:0]        green_o,
  output logic [6:0]        blue_o,
  output logic              bad_coord_o
);

  localparam int CW = $clog2(GRID_WIDTH);
  localparam int RW = $clog2(GRID_HEIGHT);
  localparam int EW = $bits(kind_e) + 3 * CW + 3 * RW + HEAT_W;
  localparam int Q_DEPTH = 2;

  logic          q_push, q_full, q_pop, q_empty, clearing;
  logic [EW-1:0] q_in, q_head;

  fehu_front #(
    .GRID_WIDTH  (GRID_WIDTH),
    .GRID_HEIGHT (GRID_HEIGHT)
  ) u_front (
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .cmd_i       (cmd_i),
    .col_i       (col_i),
    .row_i       (row_i),
    .seed_heat_i (seed_heat_i),
    .q_full_i    (q_full),
    .clearing_i  (clearing),
    .q_push_o    (q_push),
    .q_entry_o   (q_in)
  );

  fehu_queue #(
    .WIDTH (EW),
    .DEPTH (Q_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .data_o  (q_head)
  );

  fehu_back #(
    .GRID_WIDTH  (GRID_WIDTH),
    .GRID_HEIGHT (GRID_HEIGHT)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_empty),
    .q_head_i    (q_head),
    .q_pop_o     (q_pop),
    .clearing_o  (clearing),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .heat_o      (heat_o),
    .red_o       (red_o),
    .green_o     (green_o),
    .blue_o      (blue_o),
    .bad_coord_o (bad_coord_o)
  );

endmodule

[sim/tb_fire_effect_heat_update_top.sv]
// ----------------------------------------------------------------------------
// tb_fire_effect_heat_update_top: self-checking bench for the fire heat grid
// A directed table covers reset contents, palette clipping, out-of-range
// coordinates and the wrap of neighbor reads. Random flames follow: bottom-row
// seeds with updates climbing above them, mixed with random noise beats.
// Every result beat is compared with its table entry or a cell-level model of the heat grid.
// ----------------------------------------------------------------------------
module tb_fire_effect_heat_update_top;
  import fehu_pkg::*;

  localparam int GRID_W        = 800;
  localparam int GRID_H        = 600;
  localparam int NUM_RANDOM    = 750;
  localparam int HOLD_CYCLES   = 300;
  localparam int DRAIN_CYCLES  = 20;
  // The clear pass after reset is the longest stretch without any beat.
  localparam int STALL_LIMIT   = 3 * GRID_W * GRID_H + 10000;
  localparam int NUM_DIRECTED  = 22;

  typedef struct packed {
    logic [7:0] heat;
    logic [7:0] red;
    logic [7:0] green;
    logic [6:0] blue;
    logic       bad;
  } cell_color_t;

  typedef struct packed {
    cmd_e        cmd;
    logic [9:0]  col;
    logic [9:0]  row;
    logic [7:0]  seed;
    logic        typed;
    cell_color_t want;
  } dir_beat_t;

  localparam cell_color_t DARK = '{8'd0, 8'd0, 8'd0, 7'd0, 1'b0};
  localparam cell_color_t WHITE_HOT = '{8'd255, 8'd255, 8'd255, 7'd85, 1'b0};
  localparam cell_color_t OFF_GRID = '{8'd0, 8'd0, 8'd0, 7'd0, 1'b1};

  localparam dir_beat_t DIRECTED [NUM_DIRECTED] = '{
    '{CMD_UPDATE, 10'd0,    10'd0,    8'd0,   1'b1, DARK},
    '{CMD_UPDATE, 10'd799,  10'd599,  8'd0,   1'b1, DARK},
    '{CMD_SEED,   10'd0,    10'd0,    8'd255, 1'b1, WHITE_HOT},
    '{CMD_SEED,   10'd1,    10'd1023, 8'd255, 1'b1, WHITE_HOT},
    '{CMD_SEED,   10'd799,  10'd599,  8'd25,  1'b1, '{8'd25, 8'd250, 8'd50, 7'd8, 1'b0}},
    '{CMD_SEED,   10'd2,    10'd5,    8'd26,  1'b1, '{8'd26, 8'd255, 8'd52, 7'd8, 1'b0}},
    '{CMD_SEED,   10'd798,  10'd0,    8'd127, 1'b1, '{8'd127, 8'd255, 8'd254, 7'd42, 1'b0}},
    '{CMD_SEED,   10'd3,    10'd0,    8'd128, 1'b1, '{8'd128, 8'd255, 8'd255, 7'd42, 1'b0}},
    '{CMD_SEED,   10'd4,    10'd0,    8'd0,   1'b1, DARK},
    '{CMD_SEED,   10'd400,  10'd682,  8'd170, 1'b1, '{8'd170, 8'd255, 8'd255, 7'd56, 1'b0}},
    '{CMD_SEED,   10'd800,  10'd0,    8'd99,  1'b1, OFF_GRID},
    '{CMD_SEED,   10'd1023, 10'd1023, 8'd255, 1'b1, OFF_GRID},
    '{CMD_UPDATE, 10'd0,    10'd600,  8'd0,   1'b1, OFF_GRID},
    '{CMD_UPDATE, 10'd5,    10'd1023, 8'd0,   1'b1, OFF_GRID},
    // An update on the bottom row only reads the cell back.
    '{CMD_UPDATE, 10'd0,    10'd599,  8'd0,   1'b1, WHITE_HOT},
    // Left and right column wrap, and the two-below cell wraps to the top row.
    '{CMD_UPDATE, 10'd0,    10'd598,  8'd0,   1'b0, DARK},
    '{CMD_UPDATE, 10'd799,  10'd598,  8'd0,   1'b0, DARK},
    '{CMD_UPDATE, 10'd1,    10'd598,  8'd0,   1'b0, DARK},
    '{CMD_UPDATE, 10'd0,    10'd597,  8'd0,   1'b0, DARK},
    '{CMD_UPDATE, 10'd0,    10'd0,    8'd0,   1'b0, DARK},
    '{CMD_UPDATE, 10'd799,  10'd599,  8'd0,   1'b1, '{8'd25, 8'd250, 8'd50, 7'd8, 1'b0}},
    '{CMD_UPDATE, 10'd799,  10'd597,  8'd0,   1'b0, DARK}
  };

  logic       clk_i;
  logic       rst_ni      = 1'b0;
  logic       in_valid_i  = 1'b0;
  logic       in_ready_o;
  logic       cmd_i       = 1'b0;
  logic [9:0] col_i       = '0;
  logic [9:0] row_i       = '0;
  logic [7:0] seed_heat_i = '0;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  logic [7:0] heat_o;
  logic [7:0] red_o;
  logic [7:0] green_o;
  logic [6:0] blue_o;
  logic       bad_coord_o;

  // Model of the heat grid; bit cells start out at zero like the cleared RAM.
  bit [7:0]    heat_mem [GRID_W * GRID_H];
  cell_color_t pending_colors [$];

  logic        offer_typed = 1'b0;
  cell_color_t offer_want  = '0;
  int          src_idle_pct  = 6;
  int          sink_idle_pct = 45;
  bit          hold_req      = 1'b0;
  int          errors   = 0;
  int          beats_in = 0;
  int          n_seed   = 0;
  int          n_update = 0;
  int          n_bad    = 0;
  int          quiet_cycles = 0;

  fire_effect_heat_update_top #(
    .GRID_WIDTH (GRID_W),
    .GRID_HEIGHT(GRID_H)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .cmd_i      (cmd_i),
    .col_i      (col_i),
    .row_i      (row_i),
    .seed_heat_i(seed_heat_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .heat_o     (heat_o),
    .red_o      (red_o),
    .green_o    (green_o),
    .blue_o     (blue_o),
    .bad_coord_o(bad_coord_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Applies one beat to the grid model and returns the cell and its palette.
  function automatic cell_color_t next_cell_color(cmd_e c, logic [9:0] cl, logic [9:0] rw,
                                                  logic [7:0] sh);
    cell_color_t res;
    int x, y, xr, xl, y1, y2, sum, h;
    res = '0;
    x = cl;
    y = rw;
    if (x >= GRID_W || (c == CMD_UPDATE && y >= GRID_H)) begin
      res.bad = 1'b1;
      return res;
    end
    if (c == CMD_SEED) begin
      y = GRID_H - 1;
      heat_mem[y * GRID_W + x] = sh;
    end else if (y != GRID_H - 1) begin
      xr = (x + 1) % GRID_W;
      xl = (x + GRID_W - 1) % GRID_W;
      y1 = (y + 1) % GRID_H;
      y2 = (y + 2) % GRID_H;
      sum = int'(heat_mem[y1 * GRID_W + xr]) + int'(heat_mem[y1 * GRID_W + x])
          + int'(heat_mem[y1 * GRID_W + xl]) + int'(heat_mem[y2 * GRID_W + x]);
      heat_mem[y * GRID_W + x] = 8'(sum * 32 / 129);
    end
    h = heat_mem[y * GRID_W + x];
    res.heat  = 8'(h);
    res.red   = 8'((h * 10 > 255) ? 255 : h * 10);
    res.green = 8'((h * 2 > 255) ? 255 : h * 2);
    res.blue  = 7'(h / 3);
    return res;
  endfunction

  task automatic check_field(string name, int want, int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      errors++;
    end
  endtask

  // Both channels are sampled here; results are checked before the new input
  // beat is queued since a beat can never come out in the cycle it goes in.
  always @(posedge clk_i) begin
    cell_color_t want, got;
    if (out_valid_o && out_ready_i) begin
      got = '{heat_o, red_o, green_o, blue_o, bad_coord_o};
      if (pending_colors.size() == 0) begin
        $display("%0t: result beat with no expectation, actual heat %0d bad %0d",
                 $time, heat_o, bad_coord_o);
        errors++;
      end else begin
        want = pending_colors.pop_front();
        check_field("heat", want.heat, got.heat);
        check_field("red", want.red, got.red);
        check_field("green", want.green, got.green);
        check_field("blue", want.blue, got.blue);
        check_field("bad_coord", want.bad, got.bad);
      end
    end
    if (in_valid_i && in_ready_o) begin
      want = next_cell_color(cmd_e'(cmd_i), col_i, row_i, seed_heat_i);
      if (want.bad) n_bad++;
      else if (cmd_i == CMD_SEED) n_seed++;
      else n_update++;
      pending_colors.push_back(offer_typed ? offer_want : want);
    end
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t: no beat moved for %0d cycles", $time, quiet_cycles);
        $display("FAILURE");
        $finish;
      end
    end
  end

  // Result side: random stalls, plus one long hold-off when asked for.
  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        hold_req = 1'b0;
      end
      out_ready_i <= (sink_idle_pct == 0) || ($urandom_range(99) >= sink_idle_pct);
    end
  end

  task automatic send_beat(cmd_e c, logic [9:0] cl, logic [9:0] rw, logic [7:0] sh,
                           logic typed, cell_color_t want);
    @(negedge clk_i);
    while (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i  <= 1'b1;
    cmd_i       <= c;
    col_i       <= cl;
    row_i       <= rw;
    seed_heat_i <= sh;
    offer_typed = typed;
    offer_want  = want;
    do @(posedge clk_i); while (!in_ready_o);
    beats_in++;
  endtask

  task automatic send_noise();
    send_beat($urandom_range(1) ? CMD_UPDATE : CMD_SEED, 10'($urandom_range(1023)),
              10'($urandom_range(1023)), 8'($urandom_range(255)), 1'b0, '0);
  endtask

  // A flame: seed a band of the bottom row, then let the heat climb a few
  // rows. Bands often sit at the grid edges so that the column reads wrap.
  task automatic send_flame();
    int width, depth, start, c;
    int unsigned pick;
    width = $urandom_range(2, 6);
    depth = $urandom_range(1, 5);
    pick  = $urandom_range(2);
    if (pick == 0) start = GRID_W - 1 - $urandom_range(4);
    else if (pick == 1) start = $urandom_range(1);
    else start = $urandom_range(GRID_W - 1);
    for (int i = 0; i < width; i++) begin
      c = (start + i) % GRID_W;
      send_beat(CMD_SEED, 10'(c), 10'($urandom_range(1023)),
                $urandom_range(1) ? 8'($urandom_range(128, 255)) : 8'($urandom_range(255)),
                1'b0, '0);
    end
    for (int d = 0; d < depth; d++) begin
      for (int i = 0; i < width; i++) begin
        c = (start + i) % GRID_W;
        send_beat(CMD_UPDATE, 10'(c), 10'(GRID_H - 2 - d), 8'($urandom_range(255)),
                  1'b0, '0);
      end
    end
    if ($urandom_range(2) == 0) begin
      c = (start + $urandom_range(width - 1)) % GRID_W;
      send_beat(CMD_UPDATE, 10'(c), $urandom_range(1) ? 10'(GRID_H - 1) : 10'($urandom_range(2)),
                8'($urandom_range(255)), 1'b0, '0);
    end
  endtask

  task automatic run_random(int goal);
    while (beats_in < goal) begin
      if ($urandom_range(4) == 0) send_noise();
      else send_flame();
    end
  endtask

  initial begin
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
    wait (rst_ni);

    foreach (DIRECTED[i]) begin
      send_beat(DIRECTED[i].cmd, DIRECTED[i].col, DIRECTED[i].row, DIRECTED[i].seed,
                DIRECTED[i].typed, DIRECTED[i].want);
    end

    run_random(NUM_DIRECTED + NUM_RANDOM / 3);
    src_idle_pct  = 45;
    sink_idle_pct = 6;
    run_random(NUM_DIRECTED + 2 * NUM_RANDOM / 3);
    src_idle_pct  = 0;
    sink_idle_pct = 0;
    // The result side stalls while beats keep coming, so the queue fills up.
    hold_req = 1'b1;
    run_random(NUM_DIRECTED + NUM_RANDOM);

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_colors.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Run covered %0d seed, %0d update and %0d out-of-range beats", n_seed,
             n_update, n_bad);
    $display("under three stall profiles and one %0d-cycle result hold-off.", HOLD_CYCLES);
    if (errors == 0 && pending_colors.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
